@@ sv/module_image_crc24_framer_defines.svh @@
// assertion macros for the module image framer
// used by the top level only, no other dependencies
`ifndef MODULE_IMAGE_CRC24_FRAMER_DEFINES_SVH
`define MODULE_IMAGE_CRC24_FRAMER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ sv/mic24_pkg.sv @@
// shared types, constants and the crc byte update for the module image framer
// no dependencies
package mic24_pkg;

    typedef enum logic [1:0] {
        KIND_START  = 2'd0,
        KIND_NAME   = 2'd1,
        KIND_BODY   = 2'd2,
        KIND_FINISH = 2'd3
    } t_kind;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int STEP_W     = 4;

    localparam logic [CFG_IDX_W-1:0] REG_MOD_LEN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NAME_OFFSET  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TYPE_LANG    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ATTR_BYTE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EXEC_OFFSET  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STORAGE_SIZE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_EDITION_NUM  = 3'd6;

    localparam logic [7:0]  TYPE_LANG_RESET = 8'h11;
    localparam logic [7:0]  ATTR_BYTE_RESET = 8'h81;
    localparam logic [23:0] CRC_INIT        = 24'hFFFFFF;
    localparam logic [7:0]  SYNC_HI         = 8'h87;
    localparam logic [7:0]  SYNC_LO         = 8'hCD;
    localparam logic [7:0]  TOP_BIT         = 8'h80;
    localparam logic [7:0]  CRC_LOW_TAP     = 8'h21;

    // last step index of each run
    localparam logic [STEP_W-1:0] END_SINGLE    = 4'd0;
    localparam logic [STEP_W-1:0] END_NAME_LAST = 4'd1;
    localparam logic [STEP_W-1:0] END_FINISH    = 4'd2;
    localparam logic [STEP_W-1:0] END_HEADER    = 4'd12;

    typedef struct packed {
        t_kind             kind;
        logic [7:0]        data;
        logic              last;
        logic [STEP_W-1:0] run_end;
    } t_item;

    typedef struct packed {
        logic [15:0] mod_len;
        logic [15:0] name_offset;
        logic [7:0]  type_lang;
        logic [7:0]  attr_byte;
        logic [15:0] exec_offset;
        logic [15:0] storage_size;
        logic [7:0]  edition_num;
    } t_cfg;

    typedef struct packed {
        logic              fire;
        logic              head_valid;
        t_kind             kind;
        logic [STEP_W-1:0] step;
        logic [23:0]       crc;
    } t_back_stat;

    function automatic logic [23:0] crc_feed(input logic [23:0] crc, input logic [7:0] b);
        logic [7:0] a;
        logic [7:0] n0;
        logic [7:0] n1;
        logic [7:0] n2;
        a  = b ^ crc[23:16];
        n0 = crc[15:8];
        n1 = crc[7:0] ^ {7'd0, a[7]} ^ {2'd0, a[7:2]};
        n2 = {a[6:0], 1'b0} ^ {a[1:0], 6'd0};
        if (^a) begin
            n0 = n0 ^ TOP_BIT;
            n2 = n2 ^ CRC_LOW_TAP;
        end
        return {n0, n1, n2};
    endfunction

endpackage

@@ sv/mic24_front.sv @@
// front end: accepts input transactions, classifies them by run length
// and queues them for the back end; depends on mic24_pkg
module mic24_front #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // data_byte
    input  logic [1:0]         s_axis_tuser,   // kind
    input  logic               s_axis_tlast,   // name_last
    output mic24_pkg::t_item   o_head,
    output logic               o_head_valid,
    input  logic               i_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    mic24_pkg::t_item r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    mic24_pkg::t_item w_item;
    logic             w_push;

    always_comb begin
        w_item.kind = mic24_pkg::t_kind'(s_axis_tuser);
        w_item.data = s_axis_tdata;
        w_item.last = s_axis_tlast;
        unique case (w_item.kind)
            mic24_pkg::KIND_START:  w_item.run_end = mic24_pkg::END_HEADER;
            mic24_pkg::KIND_NAME:   w_item.run_end = s_axis_tlast ? mic24_pkg::END_NAME_LAST
                                                                  : mic24_pkg::END_SINGLE;
            mic24_pkg::KIND_FINISH: w_item.run_end = mic24_pkg::END_FINISH;
            default:                w_item.run_end = mic24_pkg::END_SINGLE;
        endcase
    end

    assign s_axis_tready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign w_push        = s_axis_tvalid && s_axis_tready;
    assign o_head        = r_mem[r_rd_ptr];
    assign o_head_valid  = (r_count != '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({w_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

endmodule

@@ sv/mic24_back.sv @@
// back end: steps through each queued item's run one byte a cycle
// while the output is not stalled, keeps the crc and holds the output register; depends on mic24_pkg
module mic24_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mic24_pkg::t_item      i_head,
    input  logic                  i_head_valid,
    output logic                  o_pop,
    input  mic24_pkg::t_cfg       i_cfg,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,   // out_byte
    output logic                  m_axis_tlast,   // run_last
    output mic24_pkg::t_back_stat o_stat
);

    logic [mic24_pkg::STEP_W-1:0] r_step, n_step;
    logic [23:0]                  r_crc, n_crc;
    logic                         r_out_valid, n_out_valid;
    logic [7:0]                   r_out_byte;
    logic                         r_out_last;
    logic                         w_fire;
    logic                         w_run_end;
    logic [7:0]                   w_byte;
    logic [7:0]                   w_par;
    logic [23:0]                  w_crc_base;

    assign w_fire    = i_head_valid && (!r_out_valid || m_axis_tready);
    assign w_run_end = (r_step == i_head.run_end);
    assign o_pop     = w_fire && w_run_end;

    assign w_par = ~(mic24_pkg::SYNC_HI ^ mic24_pkg::SYNC_LO
                   ^ i_cfg.mod_len[15:8] ^ i_cfg.mod_len[7:0]
                   ^ i_cfg.name_offset[15:8] ^ i_cfg.name_offset[7:0]
                   ^ i_cfg.type_lang ^ i_cfg.attr_byte);

    always_comb begin
        w_byte = i_head.data;
        case (i_head.kind)
            mic24_pkg::KIND_START: begin
                case (r_step)
                    4'd0:    w_byte = mic24_pkg::SYNC_HI;
                    4'd1:    w_byte = mic24_pkg::SYNC_LO;
                    4'd2:    w_byte = i_cfg.mod_len[15:8];
                    4'd3:    w_byte = i_cfg.mod_len[7:0];
                    4'd4:    w_byte = i_cfg.name_offset[15:8];
                    4'd5:    w_byte = i_cfg.name_offset[7:0];
                    4'd6:    w_byte = i_cfg.type_lang;
                    4'd7:    w_byte = i_cfg.attr_byte;
                    4'd8:    w_byte = w_par;
                    4'd9:    w_byte = i_cfg.exec_offset[15:8];
                    4'd10:   w_byte = i_cfg.exec_offset[7:0];
                    4'd11:   w_byte = i_cfg.storage_size[15:8];
                    default: w_byte = i_cfg.storage_size[7:0];
                endcase
            end
            mic24_pkg::KIND_NAME: begin
                if (!i_head.last) begin
                    w_byte = i_head.data;
                end else if (r_step == '0) begin
                    w_byte = i_head.data | mic24_pkg::TOP_BIT;
                end else begin
                    w_byte = i_cfg.edition_num;
                end
            end
            mic24_pkg::KIND_FINISH: begin
                case (r_step)
                    4'd0:    w_byte = ~r_crc[23:16];
                    4'd1:    w_byte = ~r_crc[15:8];
                    default: w_byte = ~r_crc[7:0];
                endcase
            end
            default: w_byte = i_head.data;
        endcase
    end

    // a start run seeds the crc with all ones before its first byte
    assign w_crc_base = (i_head.kind == mic24_pkg::KIND_START && r_step == '0)
                        ? mic24_pkg::CRC_INIT : r_crc;

    always_comb begin
        n_crc       = r_crc;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        if (w_fire) begin
            n_out_valid = 1'b1;
            n_step      = w_run_end ? '0 : r_step + 1'b1;
            if (i_head.kind != mic24_pkg::KIND_FINISH) begin
                n_crc = mic24_pkg::crc_feed(w_crc_base, w_byte);
            end
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= mic24_pkg::CRC_INIT;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_crc       <= n_crc;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_byte <= w_byte;
            r_out_last <= w_run_end;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tlast  = r_out_last;

    assign o_stat.fire       = w_fire;
    assign o_stat.head_valid = i_head_valid;
    assign o_stat.kind       = i_head.kind;
    assign o_stat.step       = r_step;
    assign o_stat.crc        = r_crc;

endmodule

@@ sv/module_image_crc24_framer.sv @@
// top level of the module image framer: configuration registers, front and back ends
// depends on mic24_pkg, mic24_front, mic24_back and the assertion macro header

// Each input transaction is classified and queued by the front end (QUEUE_DEPTH entries);
// the back end emits the bytes of the item at the queue head one per cycle into an output
// register while it is not stalled. Body bytes and plain name characters emit one byte, a
// last name character two (character with bit 7 set, then the edition byte), a start item
// the thirteen header bytes and a finish item the three inverted crc bytes. The 24-bit crc
// is seeded to all ones by a start item and updated by every byte except the crc bytes.
// tlast marks the last byte of each item's run. Input items are registered in the queue and
// then in the output register. Configuration writes must be made while the block is idle.
`include "module_image_crc24_framer_defines.svh"

module module_image_crc24_framer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mic24_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mic24_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // data_byte
    input  logic [1:0]                      s_axis_tuser,   // kind
    input  logic                            s_axis_tlast,   // name_last
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [7:0]                      m_axis_tdata,   // out_byte
    output logic                            m_axis_tlast    // run_last
);

    mic24_pkg::t_cfg       r_cfg, n_cfg;
    mic24_pkg::t_item      w_head;
    logic                  w_head_valid;
    logic                  w_pop;
    mic24_pkg::t_back_stat w_stat;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mic24_pkg::REG_MOD_LEN:      n_cfg.mod_len      = i_cfg_data;
                mic24_pkg::REG_NAME_OFFSET:  n_cfg.name_offset  = i_cfg_data;
                mic24_pkg::REG_TYPE_LANG:    n_cfg.type_lang    = i_cfg_data[7:0];
                mic24_pkg::REG_ATTR_BYTE:    n_cfg.attr_byte    = i_cfg_data[7:0];
                mic24_pkg::REG_EXEC_OFFSET:  n_cfg.exec_offset  = i_cfg_data;
                mic24_pkg::REG_STORAGE_SIZE: n_cfg.storage_size = i_cfg_data;
                mic24_pkg::REG_EDITION_NUM:  n_cfg.edition_num  = i_cfg_data[7:0];
                default:                     n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mod_len      <= '0;
            r_cfg.name_offset  <= '0;
            r_cfg.type_lang    <= mic24_pkg::TYPE_LANG_RESET;
            r_cfg.attr_byte    <= mic24_pkg::ATTR_BYTE_RESET;
            r_cfg.exec_offset  <= '0;
            r_cfg.storage_size <= '0;
            r_cfg.edition_num  <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    mic24_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .o_head        (w_head),
        .o_head_valid  (w_head_valid),
        .i_pop         (w_pop)
    );

    mic24_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .i_head_valid  (w_head_valid),
        .o_pop         (w_pop),
        .i_cfg         (r_cfg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .o_stat        (w_stat)
    );

    // crc bytes leave the crc untouched
    `ASSERT_NEXT(a_finish_keeps_crc, i_clk, i_rst_n, w_stat.fire && w_stat.kind == mic24_pkg::KIND_FINISH, $stable(w_stat.crc))
    // the first header byte is fed into a freshly seeded crc
    `ASSERT_NEXT(a_start_seeds_crc, i_clk, i_rst_n, w_stat.fire && w_stat.kind == mic24_pkg::KIND_START && w_stat.step == '0, w_stat.crc == mic24_pkg::crc_feed(mic24_pkg::CRC_INIT, mic24_pkg::SYNC_HI))
    // the back end only pops a queue entry that is there
    `ASSERT_IMPLIES(a_pop_needs_head, i_clk, i_rst_n, w_pop, w_stat.head_valid && w_stat.fire)
    // the step counter returns to zero after each run
    `ASSERT_NEXT(a_step_resets_at_end, i_clk, i_rst_n, w_pop, w_stat.step == '0)

endmodule

@@ test/tb.sv @@
// self-checking testbench for module_image_crc24_framer: directed and random image streams
// predicts header, name, body and crc bytes in-line and checks them against the output stream
// depends on mic24_pkg and the framer rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [mic24_pkg::CFG_IDX_W-1:0] REG_NONE = 3'd7;
    localparam int TOTAL_ITEMS             = 470;
    localparam int HOLD_CYCLES             = 80;
    localparam int DRAIN_LIMIT             = 100000;

    typedef struct packed {
        logic [7:0] value;
        logic       is_last;
    } t_image_byte;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_cfg_we = 1'b0;
    logic [mic24_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [mic24_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [7:0]                       s_axis_tdata = '0;   // data_byte
    logic [1:0]                       s_axis_tuser = '0;   // kind
    logic                             s_axis_tlast = 1'b0; // name_last
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [7:0]                       m_axis_tdata;        // out_byte
    logic                             m_axis_tlast;        // run_last

    // predictor state
    logic [15:0] cfg_mod_len;
    logic [15:0] cfg_name_offset;
    logic [7:0]  cfg_type_lang;
    logic [7:0]  cfg_attr_byte;
    logic [15:0] cfg_exec_offset;
    logic [15:0] cfg_storage_size;
    logic [7:0]  cfg_edition_num;
    logic [23:0] image_crc;
    t_image_byte expected_bytes[$];

    int items_sent    = 0;
    int bytes_checked = 0;
    int err_count     = 0;
    int phases_run    = 0;
    int burst_left    = 0;
    int hold_requests = 0;
    int holds_done    = 0;
    int hold_cnt      = 0;
    int rx_mode       = 0;
    int rx_left       = 0;
    int rx_tick       = 0;
    t_image_byte rx_want;

    module_image_crc24_framer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #400000;
        $display("FAILURE");
        $finish;
    end

    // byte-wide crc-24 update, leading byte in bits 23..16
    function automatic logic [23:0] crc24_update(input logic [23:0] crc, input logic [7:0] b);
        logic [7:0] a;
        logic [7:0] n0;
        logic [7:0] n1;
        logic [7:0] n2;
        a  = b ^ crc[23:16];
        n0 = crc[15:8];
        n1 = crc[7:0] ^ (a >> 7) ^ (a >> 2);
        n2 = (a << 1) ^ (a << 6);
        if (^a) begin
            n0 = n0 ^ mic24_pkg::TOP_BIT;
            n2 = n2 ^ mic24_pkg::CRC_LOW_TAP;
        end
        return {n0, n1, n2};
    endfunction

    function automatic void emit_byte(input logic [7:0] b, input logic fold, input logic is_last);
        expected_bytes.push_back('{value: b, is_last: is_last});
        if (fold) begin
            image_crc = crc24_update(image_crc, b);
        end
    endfunction

    function automatic void predict_image_bytes(input mic24_pkg::t_kind k, input logic [7:0] d,
                                                input logic l);
        logic [63:0] head;
        logic [7:0]  check;
        int          i;
        case (k)
            mic24_pkg::KIND_START: begin
                image_crc = mic24_pkg::CRC_INIT;
                head  = {mic24_pkg::SYNC_HI, mic24_pkg::SYNC_LO, cfg_mod_len, cfg_name_offset,
                         cfg_type_lang, cfg_attr_byte};
                check = 8'hFF;
                for (i = 7; i >= 0; i--) begin
                    emit_byte(head[i*8 +: 8], 1'b1, 1'b0);
                    check = check ^ head[i*8 +: 8];
                end
                emit_byte(check, 1'b1, 1'b0);
                emit_byte(cfg_exec_offset[15:8], 1'b1, 1'b0);
                emit_byte(cfg_exec_offset[7:0], 1'b1, 1'b0);
                emit_byte(cfg_storage_size[15:8], 1'b1, 1'b0);
                emit_byte(cfg_storage_size[7:0], 1'b1, 1'b1);
            end
            mic24_pkg::KIND_NAME: begin
                if (l) begin
                    emit_byte(d | mic24_pkg::TOP_BIT, 1'b1, 1'b0);
                    emit_byte(cfg_edition_num, 1'b1, 1'b1);
                end else begin
                    emit_byte(d, 1'b1, 1'b1);
                end
            end
            mic24_pkg::KIND_BODY: begin
                emit_byte(d, 1'b1, 1'b1);
            end
            default: begin
                // crc bytes do not fold back into the crc
                emit_byte(~image_crc[23:16], 1'b0, 1'b0);
                emit_byte(~image_crc[15:8], 1'b0, 1'b0);
                emit_byte(~image_crc[7:0], 1'b0, 1'b1);
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        err_count++;
        if (err_count <= 40) begin
            $display("mismatch in %s at byte %0d: got %02h, expected %02h",
                     what, bytes_checked, got, want);
        end
    endtask

    // output checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            bytes_checked++;
            if (expected_bytes.size() == 0) begin
                report_mismatch("unexpected transaction", m_axis_tdata, 8'h00);
            end else begin
                rx_want = expected_bytes.pop_front();
                if (m_axis_tdata !== rx_want.value) begin
                    report_mismatch("out_byte", m_axis_tdata, rx_want.value);
                end
                if (m_axis_tlast !== rx_want.is_last) begin
                    report_mismatch("run_last", {7'd0, m_axis_tlast}, {7'd0, rx_want.is_last});
                end
            end
        end
    end

    // receiver stall pattern, with long hold-offs on request
    always @(posedge i_clk) begin
        if (hold_cnt != 0) begin
            hold_cnt--;
            m_axis_tready <= 1'b0;
        end else if (hold_requests != holds_done) begin
            holds_done++;
            hold_cnt = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(20, 150);
            end else begin
                rx_left--;
            end
            rx_tick++;
            case (rx_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                2: m_axis_tready <= (rx_tick % 3) != 0;
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic send_item(input mic24_pkg::t_kind k, input logic [7:0] d, input logic l);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 5);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= k;
        s_axis_tlast  <= l;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        predict_image_bytes(k, d, l);
        items_sent++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_bytes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [mic24_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        case (idx)
            mic24_pkg::REG_MOD_LEN:      cfg_mod_len      = value;
            mic24_pkg::REG_NAME_OFFSET:  cfg_name_offset  = value;
            mic24_pkg::REG_TYPE_LANG:    cfg_type_lang    = value[7:0];
            mic24_pkg::REG_ATTR_BYTE:    cfg_attr_byte    = value[7:0];
            mic24_pkg::REG_EXEC_OFFSET:  cfg_exec_offset  = value;
            mic24_pkg::REG_STORAGE_SIZE: cfg_storage_size = value;
            mic24_pkg::REG_EDITION_NUM:  cfg_edition_num  = value[7:0];
            default: ;
        endcase
    endtask

    // writes every register plus the unused index, block must be idle
    task automatic load_settings(input logic [15:0] sz, input logic [15:0] noff,
                                 input logic [15:0] tl, input logic [15:0] ar,
                                 input logic [15:0] ex, input logic [15:0] st,
                                 input logic [15:0] ed);
        wait_idle();
        write_reg(mic24_pkg::REG_MOD_LEN, sz);
        write_reg(mic24_pkg::REG_NAME_OFFSET, noff);
        write_reg(mic24_pkg::REG_TYPE_LANG, tl);
        write_reg(mic24_pkg::REG_ATTR_BYTE, ar);
        write_reg(mic24_pkg::REG_EXEC_OFFSET, ex);
        write_reg(mic24_pkg::REG_STORAGE_SIZE, st);
        write_reg(mic24_pkg::REG_EDITION_NUM, ed);
        write_reg(REG_NONE, 16'($urandom_range(0, 65535)));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        phases_run++;
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_image(input int max_body);
        int n_name;
        int n_body;
        int i;
        n_name = $urandom_range(1, 8);
        n_body = $urandom_range(0, max_body);
        send_item(mic24_pkg::KIND_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        for (i = 0; i < n_name; i++) begin
            send_item(mic24_pkg::KIND_NAME, 8'($urandom_range(0, 255)), i == n_name - 1);
        end
        if ($urandom_range(0, 7) == 0) begin
            send_item(mic24_pkg::KIND_NAME, 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
        end
        for (i = 0; i < n_body; i++) begin
            send_item(mic24_pkg::KIND_BODY, 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
        end
        send_item(mic24_pkg::KIND_FINISH, 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
        if ($urandom_range(0, 9) == 0) begin
            send_item(mic24_pkg::KIND_FINISH, 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
        end
    endtask

    task automatic send_noise();
        int n;
        int i;
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++) begin
            send_item(mic24_pkg::t_kind'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_items_before_start();
        send_item(mic24_pkg::KIND_BODY, 8'h00, 1'b1);
        send_item(mic24_pkg::KIND_NAME, 8'hFF, 1'b0);
        send_item(mic24_pkg::KIND_FINISH, 8'hFF, 1'b1);
    endtask

    task automatic test_reset_header();
        send_item(mic24_pkg::KIND_START, 8'hFF, 1'b1);
        send_item(mic24_pkg::KIND_NAME, 8'h00, 1'b0);
        send_item(mic24_pkg::KIND_NAME, 8'h7F, 1'b1);
        // another name character after the one marked last
        send_item(mic24_pkg::KIND_NAME, 8'hFF, 1'b1);
        send_item(mic24_pkg::KIND_BODY, 8'hFF, 1'b0);
        send_item(mic24_pkg::KIND_FINISH, 8'h00, 1'b0);
        send_item(mic24_pkg::KIND_FINISH, 8'h00, 1'b0);
    endtask

    task automatic test_register_extremes();
        load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(mic24_pkg::KIND_START, 8'h00, 1'b0);
        send_item(mic24_pkg::KIND_NAME, 8'h80, 1'b1);
        send_item(mic24_pkg::KIND_FINISH, 8'h00, 1'b0);
        load_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_item(mic24_pkg::KIND_START, 8'h00, 1'b0);
        send_item(mic24_pkg::KIND_FINISH, 8'h00, 1'b0);
    endtask

    task automatic test_restart_mid_image();
        load_settings(16'h1234, 16'h000D, 16'h0021, 16'h0081, 16'h0040, 16'h0100, 16'h0001);
        send_item(mic24_pkg::KIND_START, 8'h00, 1'b0);
        send_item(mic24_pkg::KIND_BODY, 8'h5A, 1'b0);
        send_item(mic24_pkg::KIND_START, 8'h00, 1'b0);
        send_item(mic24_pkg::KIND_BODY, 8'hA5, 1'b0);
        send_item(mic24_pkg::KIND_FINISH, 8'h00, 1'b0);
    endtask

    task automatic test_output_hold();
        load_settings(pick_word(), pick_word(), pick_word(), pick_word(),
                      pick_word(), pick_word(), pick_word());
        hold_requests++;
        repeat (3) send_image(16);
    endtask

    task automatic test_random_images();
        int phase_start;
        while (items_sent < TOTAL_ITEMS) begin
            load_settings(pick_word(), pick_word(), pick_word(), pick_word(),
                          pick_word(), pick_word(), pick_word());
            phase_start = items_sent;
            while (items_sent - phase_start < 60 && items_sent < TOTAL_ITEMS) begin
                if ($urandom_range(0, 99) < 15) begin
                    send_noise();
                end else begin
                    send_image(($urandom_range(0, 7) == 0) ? 40 : 12);
                end
            end
        end
    endtask

    initial begin
        int guard;
        cfg_mod_len      = '0;
        cfg_name_offset  = '0;
        cfg_type_lang    = mic24_pkg::TYPE_LANG_RESET;
        cfg_attr_byte    = mic24_pkg::ATTR_BYTE_RESET;
        cfg_exec_offset  = '0;
        cfg_storage_size = '0;
        cfg_edition_num  = '0;
        image_crc        = mic24_pkg::CRC_INIT;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_items_before_start();
        test_reset_header();
        test_register_extremes();
        test_restart_mid_image();
        test_output_hold();
        test_random_images();

        s_axis_tvalid <= 1'b0;
        guard = 0;
        while (expected_bytes.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (16) @(posedge i_clk);
        if (expected_bytes.size() != 0) begin
            report_mismatch("missing transactions", 8'h00, 8'(expected_bytes.size()));
        end

        $display("covered %0d input items over %0d register settings, %0d output bytes checked",
                 items_sent, phases_run, bytes_checked);
        $display("receiver held off %0d times, %0d mismatches", holds_done, err_count);
        if (err_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
